### hdl/atab_pkg.sv
// Shared types and constants for the address range table.
// Depends on nothing; used by atab_ctrl, atab_dp and the top level.
package atab_pkg;

  typedef enum logic [2:0] {
    OP_FIND   = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SPLIT  = 3'd3,
    OP_GAP    = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_EV,
    ST_NEXT,
    ST_FREE,
    ST_WNEW,
    ST_WMOD,
    ST_GCHK,
    ST_GDEC,
    ST_OUT
  } st_e;

  localparam logic [31:0] GAP_LIMIT_RST   = 32'h4000_0000;
  localparam logic [31:0] NEXT_SEARCH_RST = 32'h2000_0000;
  localparam logic [26:0] PAGES_MAX       = 27'h7FF_FFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [31:0] lookup_addr;
    logic [31:0] request_length;
    logic [31:0] area_flags;
    logic [7:0]  area_type;
  } item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] hit_start;
    logic [31:0] hit_end;
    logic [31:0] hit_flags;
    logic [7:0]  hit_type;
    logic [26:0] removed_pages;
    logic [31:0] free_address;
    logic [6:0]  area_count;
    logic [31:0] mapped_bytes;
  } result_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic idx_next;
    logic idx_clr;
    logic free_step;
    logic wr_new;
    logic wr_mod;
    logic gap_dec;
    logic set_ok;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       range_ok;
    logic       len_ok;
    logic       hit;
    logic       at_start;
    logic       rm_write;
    logic       punch;
    logic       last;
    logic       free_found;
    logic       free_last;
    logic       gap_stop;
    logic       ovl;
    logic       out_busy;
  } sts_t;

endpackage

### hdl/atab_in_if.sv
// Request channel of the address range table.
// Standalone; carries valid, ready and one request item.
interface atab_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic [31:0] lookup_addr;
  logic [31:0] request_length;
  logic [31:0] area_flags;
  logic [7:0]  area_type;

  modport source (output valid, mode, range_start, range_end, lookup_addr,
                  request_length, area_flags, area_type, input ready);
  modport sink (input valid, mode, range_start, range_end, lookup_addr,
                request_length, area_flags, area_type, output ready);
endinterface

### hdl/atab_out_if.sv
// Result channel of the address range table.
// Standalone; carries valid, ready and one result item.
interface atab_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] hit_start;
  logic [31:0] hit_end;
  logic [31:0] hit_flags;
  logic [7:0]  hit_type;
  logic [26:0] removed_pages;
  logic [31:0] free_address;
  logic [6:0]  area_count;
  logic [31:0] mapped_bytes;

  modport source (output valid, status, hit_start, hit_end, hit_flags, hit_type,
                  removed_pages, free_address, area_count, mapped_bytes, input ready);
  modport sink (input valid, status, hit_start, hit_end, hit_flags, hit_type,
                removed_pages, free_address, area_count, mapped_bytes, output ready);
endinterface

### hdl/atab_cfg_if.sv
// Configuration write channel of the address range table.
// Standalone; carries valid, ready and the gap limit value.
interface atab_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] gap_limit;

  modport source (output valid, gap_limit, input ready);
  modport sink (input valid, gap_limit, output ready);
endinterface

### hdl/atab_ram.sv
// Generic single write port RAM with registered read.
// Standalone; holds the entry table.
module atab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/atab_ctrl.sv
// Sequencer for the address range table.
// Uses atab_pkg; drives commands to atab_dp and reads its status.
module atab_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  atab_pkg::sts_t sts_i,
  output atab_pkg::cmd_t cmd_o
);
  import atab_pkg::*;

  st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: begin
        case (sts_i.op)
          OP_FIND, OP_SPLIT: state_d = ST_RD;
          OP_REMOVE: state_d = sts_i.range_ok ? ST_RD : ST_OUT;
          OP_INSERT: state_d = sts_i.range_ok ? ST_FREE : ST_OUT;
          OP_GAP:    state_d = sts_i.len_ok ? ST_GCHK : ST_OUT;
          default:   state_d = ST_OUT;
        endcase
      end
      ST_RD: state_d = ST_EV;
      ST_EV: begin
        case (sts_i.op)
          OP_FIND:   state_d = sts_i.hit ? ST_OUT : ST_NEXT;
          OP_SPLIT:  state_d = sts_i.hit ? (sts_i.at_start ? ST_OUT : ST_FREE) : ST_NEXT;
          OP_REMOVE: state_d = sts_i.rm_write ? ST_WMOD : ST_NEXT;
          default:   state_d = ST_NEXT;
        endcase
      end
      ST_NEXT: begin
        if (sts_i.last) begin
          state_d = (sts_i.op == OP_GAP) ? ST_GDEC : ST_OUT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_FREE: begin
        if (sts_i.free_found) begin
          state_d = ST_WNEW;
        end else if (sts_i.free_last) begin
          state_d = (sts_i.op == OP_REMOVE) ? ST_NEXT : ST_OUT;
        end
      end
      ST_WNEW: begin
        case (sts_i.op)
          OP_INSERT: state_d = ST_OUT;
          OP_SPLIT:  state_d = ST_WMOD;
          default:   state_d = ST_NEXT;
        endcase
      end
      ST_WMOD: begin
        case (sts_i.op)
          OP_SPLIT: state_d = ST_OUT;
          default:  state_d = sts_i.punch ? ST_FREE : ST_NEXT;
        endcase
      end
      ST_GCHK: state_d = sts_i.gap_stop ? ST_OUT : ST_RD;
      ST_GDEC: state_d = sts_i.ovl ? ST_GCHK : ST_OUT;
      ST_OUT: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_START: cmd_o.set_ok = (sts_i.op == OP_REMOVE) && sts_i.range_ok;
      ST_EV: begin
        cmd_o.eval   = 1'b1;
        cmd_o.set_ok = sts_i.hit && ((sts_i.op == OP_FIND) ||
                                     ((sts_i.op == OP_SPLIT) && sts_i.at_start));
      end
      ST_NEXT: cmd_o.idx_next = !sts_i.last;
      ST_FREE: cmd_o.free_step = 1'b1;
      ST_WNEW: begin
        cmd_o.wr_new = 1'b1;
        cmd_o.set_ok = (sts_i.op == OP_INSERT);
      end
      ST_WMOD: begin
        cmd_o.wr_mod = 1'b1;
        cmd_o.set_ok = (sts_i.op == OP_SPLIT);
      end
      ST_GCHK: cmd_o.idx_clr = !sts_i.gap_stop;
      ST_GDEC: begin
        cmd_o.gap_dec = 1'b1;
        cmd_o.set_ok  = !sts_i.ovl;
      end
      ST_OUT: cmd_o.out_load = !sts_i.out_busy;
      default: ;
    endcase
  end
endmodule

### hdl/atab_dp.sv
// Datapath of the address range table: entry RAM, valid bits, counters,
// gap search registers and the result register. Uses atab_pkg and atab_ram.
module atab_dp #(
  parameter int ENTRIES      = 64,
  parameter int PAGE_BYTES   = 4096,
  parameter int SEARCH_TRIES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atab_pkg::cmd_t    cmd_i,
  output atab_pkg::sts_t    sts_o,
  input  atab_pkg::item_t   item_i,
  input  logic              cfg_valid_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output atab_pkg::result_t result_o
);
  import atab_pkg::*;

  localparam int OFF = $clog2(PAGE_BYTES);
  localparam int PW  = 32 - OFF;
  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int TW  = $clog2(SEARCH_TRIES + 1);
  localparam int EW  = 2 * PW + 40;
  localparam logic [31:0] PG_SIZE = 32'(PAGE_BYTES);
  localparam logic [31:0] PG_ADD  = PG_SIZE - 32'd1;
  localparam logic [31:0] PG_MASK = ~PG_ADD;

  typedef struct packed {
    logic [PW-1:0] start_p;
    logic [PW-1:0] end_p;
    logic [31:0]   flags;
    logic [7:0]    kind;
  } ent_t;

  function automatic logic [31:0] round_up(logic [31:0] a);
    round_up = (a + PG_ADD) & PG_MASK;
  endfunction

  item_t             item_q;
  logic [31:0]       lo_q, hi_q, len_q, cand_q, best_q, add_q;
  logic [TW-1:0]     tries_q;
  logic [IW-1:0]     idx_q, fidx_q;
  ent_t              wbuf_q, nbuf_q;
  logic              punch_q, ovl_q;
  logic [ENTRIES-1:0] valid_q;
  logic [CW-1:0]     count_q;
  logic [31:0]       total_q, nsearch_q, gap_limit_q;
  logic              res_status_q;
  logic [31:0]       hit_start_q, hit_end_q, hit_flags_q, free_q;
  logic [7:0]        hit_type_q;
  logic [32:0]       pages_q;
  logic              out_valid_q;
  result_t           out_q;

  ent_t        rd_ent;
  logic [EW-1:0] rd_raw;
  logic [31:0] vs, ve, cmp_addr, in_lo, in_hi, cend, rm_pg, rm_tot;
  logic [32:0] gsum;
  logic        v, hit, ov, full, punch, trim_lo, g_ovl, g_in, mode_rm;

  atab_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_new | cmd_i.wr_mod),
    .waddr_i (cmd_i.wr_new ? fidx_q : idx_q),
    .wdata_i (cmd_i.wr_new ? nbuf_q : wbuf_q),
    .raddr_i (idx_q),
    .rdata_o (rd_raw)
  );

  always_comb begin
    rd_ent   = rd_raw;
    vs       = {rd_ent.start_p, {OFF{1'b0}}};
    ve       = {rd_ent.end_p, {OFF{1'b0}}};
    v        = valid_q[idx_q];
    in_lo    = item_i.range_start & PG_MASK;
    in_hi    = round_up(item_i.range_end);
    cmp_addr = (item_q.mode == OP_SPLIT) ? (item_q.lookup_addr & PG_MASK)
                                         : item_q.lookup_addr;
    hit      = v && (cmp_addr >= vs) && (cmp_addr < ve);
    ov       = v && !((ve <= lo_q) || (vs >= hi_q));
    full     = (lo_q <= vs) && (hi_q >= ve);
    punch    = (lo_q > vs) && (hi_q < ve);
    trim_lo  = (lo_q <= vs);
    mode_rm  = (item_q.mode == OP_REMOVE);
    if (full) begin
      rm_pg  = ve - vs;
      rm_tot = ve - vs;
    end else if (punch) begin
      rm_pg  = hi_q - lo_q;
      rm_tot = ve - lo_q;
    end else if (trim_lo) begin
      rm_pg  = hi_q - vs;
      rm_tot = hi_q - vs;
    end else begin
      rm_pg  = ve - lo_q;
      rm_tot = ve - lo_q;
    end
    cend  = cand_q + len_q;
    g_ovl = v && (cand_q < ve) && (cend > vs);
    g_in  = v && (cand_q >= vs) && (cand_q < ve) && (ve > best_q);
    gsum  = {1'b0, cand_q} + {1'b0, len_q};
  end

  always_comb begin
    sts_o            = '0;
    sts_o.op         = item_q.mode;
    sts_o.range_ok   = item_q.range_start < item_q.range_end;
    sts_o.len_ok     = item_q.request_length != 32'd0;
    sts_o.hit        = hit;
    sts_o.at_start   = cmp_addr == vs;
    sts_o.rm_write   = ov && !full;
    sts_o.punch      = punch_q;
    sts_o.last       = idx_q == IW'(ENTRIES - 1);
    sts_o.free_found = !valid_q[fidx_q];
    sts_o.free_last  = fidx_q == IW'(ENTRIES - 1);
    sts_o.gap_stop   = gsum[32] || (gsum[31:0] > gap_limit_q) ||
                       (tries_q == TW'(SEARCH_TRIES));
    sts_o.ovl        = ovl_q;
    sts_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q       <= item_i;
      lo_q         <= in_lo;
      hi_q         <= in_hi;
      len_q        <= round_up(item_i.request_length);
      cand_q       <= nsearch_q;
      tries_q      <= '0;
      idx_q        <= '0;
      nbuf_q       <= {in_lo[31:OFF], in_hi[31:OFF], item_i.area_flags, item_i.area_type};
      add_q        <= in_hi - in_lo;
      res_status_q <= 1'b1;
      hit_start_q  <= '0;
      hit_end_q    <= '0;
      hit_flags_q  <= '0;
      hit_type_q   <= '0;
      pages_q      <= '0;
      free_q       <= '0;
      punch_q      <= 1'b0;
    end
    if (cmd_i.idx_next) idx_q <= idx_q + IW'(1);
    if (cmd_i.idx_clr) begin
      idx_q  <= '0;
      ovl_q  <= 1'b0;
      best_q <= cand_q + PG_SIZE;
    end
    if (cmd_i.eval) begin
      punch_q <= 1'b0;
      case (item_q.mode)
        OP_FIND: begin
          if (hit) begin
            hit_start_q <= vs;
            hit_end_q   <= ve;
            hit_flags_q <= rd_ent.flags;
            hit_type_q  <= rd_ent.kind;
          end
        end
        OP_SPLIT: begin
          if (hit) begin
            wbuf_q <= {rd_ent.start_p, cmp_addr[31:OFF], rd_ent.flags, rd_ent.kind};
            nbuf_q <= {cmp_addr[31:OFF], rd_ent.end_p, rd_ent.flags, rd_ent.kind};
            add_q  <= '0;
          end
        end
        OP_REMOVE: begin
          if (ov) begin
            pages_q <= pages_q + 33'(rm_pg >> OFF);
            punch_q <= punch;
            if (trim_lo) begin
              wbuf_q <= {hi_q[31:OFF], rd_ent.end_p, rd_ent.flags, rd_ent.kind};
            end else begin
              wbuf_q <= {rd_ent.start_p, lo_q[31:OFF], rd_ent.flags, rd_ent.kind};
            end
            nbuf_q <= {hi_q[31:OFF], rd_ent.end_p, rd_ent.flags, rd_ent.kind};
            add_q  <= ve - hi_q;
          end
        end
        OP_GAP: begin
          if (g_ovl) ovl_q <= 1'b1;
          if (g_in) best_q <= ve;
        end
        default: ;
      endcase
    end
    if (cmd_i.set_ok) res_status_q <= 1'b0;
    if (cmd_i.gap_dec) begin
      if (!ovl_q) begin
        free_q <= cand_q;
      end else begin
        cand_q  <= best_q;
        tries_q <= tries_q + TW'(1);
      end
    end
    if (cmd_i.free_step && !sts_o.free_found && !sts_o.free_last) begin
      fidx_q <= fidx_q + IW'(1);
    end else if (!cmd_i.free_step && !cmd_i.wr_new) begin
      fidx_q <= '0;
    end
    if (cmd_i.out_load) begin
      out_q.status        <= res_status_q;
      out_q.hit_start     <= hit_start_q;
      out_q.hit_end       <= hit_end_q;
      out_q.hit_flags     <= hit_flags_q;
      out_q.hit_type      <= hit_type_q;
      out_q.removed_pages <= (pages_q > 33'(PAGES_MAX)) ? PAGES_MAX : pages_q[26:0];
      out_q.free_address  <= free_q;
      out_q.area_count    <= 7'(count_q);
      out_q.mapped_bytes  <= total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      total_q     <= '0;
      nsearch_q   <= NEXT_SEARCH_RST;
      gap_limit_q <= GAP_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) gap_limit_q <= cfg_data_i;
      if (cmd_i.eval && mode_rm && ov) begin
        total_q <= total_q - rm_tot;
        if (full) begin
          valid_q[idx_q] <= 1'b0;
          count_q        <= count_q - CW'(1);
        end
      end
      if (cmd_i.wr_new) begin
        valid_q[fidx_q] <= 1'b1;
        count_q         <= count_q + CW'(1);
        total_q         <= total_q + add_q;
      end
      if (cmd_i.gap_dec && !ovl_q) nsearch_q <= cand_q + len_q;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;
endmodule

### hdl/address_range_table_top.sv
// Top level of the address range table: sequencer plus datapath.
// Uses atab_pkg, the atab_*_if interfaces, atab_ctrl and atab_dp.
//
//  channel  dir  role    contents
//  in_i     in   sink    mode, range, lookup address, length, flags, type
//  out_o    out  source  status, hit entry, pages, free address, counts
//  cfg_i    in   sink    gap_limit, always ready
//
// One item at a time; the entry RAM has one read port, and a scan visits
// each entry in turn through the read, evaluate and next states. Remove
// writes each trimmed entry back, and a punched hole or a split that cuts
// also searches for a free slot; insert searches for a free slot; a gap
// search rescans the table per candidate, up to SEARCH_TRIES candidates.
// A new item is taken while a result waits in the output register; a
// stalled result holds only the final handoff.
// Reset clears the valid bits at once; no clearing pass.
module address_range_table_top #(
  parameter int ENTRIES      = 64,
  parameter int PAGE_BYTES   = 4096,
  parameter int SEARCH_TRIES = 1024
) (
  input logic      clk_i,
  input logic      rst_ni,
  atab_in_if.sink  in_i,
  atab_out_if.source out_o,
  atab_cfg_if.sink cfg_i
);
  import atab_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  item_t   item;
  result_t res;
  logic    out_valid;

  assign item.mode           = in_i.mode;
  assign item.range_start    = in_i.range_start;
  assign item.range_end      = in_i.range_end;
  assign item.lookup_addr    = in_i.lookup_addr;
  assign item.request_length = in_i.request_length;
  assign item.area_flags     = in_i.area_flags;
  assign item.area_type      = in_i.area_type;

  assign cfg_i.ready = 1'b1;

  atab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  atab_dp #(
    .ENTRIES      (ENTRIES),
    .PAGE_BYTES   (PAGE_BYTES),
    .SEARCH_TRIES (SEARCH_TRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.gap_limit),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .result_o    (res)
  );

  assign out_o.valid         = out_valid;
  assign out_o.status        = res.status;
  assign out_o.hit_start     = res.hit_start;
  assign out_o.hit_end       = res.hit_end;
  assign out_o.hit_flags     = res.hit_flags;
  assign out_o.hit_type      = res.hit_type;
  assign out_o.removed_pages = res.removed_pages;
  assign out_o.free_address  = res.free_address;
  assign out_o.area_count    = res.area_count;
  assign out_o.mapped_bytes  = res.mapped_bytes;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second item taken while busy");

  a_new_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_new |-> sts.free_found)
    else $error("new entry written over a valid slot");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.eval, cmd.wr_new, cmd.wr_mod, cmd.free_step, cmd.gap_dec}))
    else $error("conflicting datapath commands");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_o.valid)
    else $error("result load lost");
endmodule
